FILE: sv/sfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Speed frame parser package
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Frame layout: payload length, CRC span and the byte index width.
  localparam int unsigned FrameLen = 10;
  localparam int unsigned CrcSpan  = 8;
  localparam int unsigned IdxW     = 4;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Configuration register indexes.
  localparam logic [7:0] RegHeader  = 8'd0;
  localparam logic [7:0] RegCommand = 8'd1;

  // Index of the last payload byte and of the CRC high byte.
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] CrcHiIdx = IdxW'(CrcSpan);

  // One classified payload byte, passed from the front end to the back end.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } pld_t;

  // Bytewise reflected CRC update, one bit per step.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sfp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Speed frame parser queue
// Short queue of classified payload bytes between front and back end.
// ----------------------------------------------------------------------------
module sfp_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sfp_pkg::pld_t item_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output sfp_pkg::pld_t      item_o
);
  import sfp_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pld_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage array; entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // The fill count never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  // The front end never writes a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("write into full queue");

endmodule
`default_nettype wire

FILE: sv/sfp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Speed frame parser front end
// Takes received bytes, hunts for the sync pair and tags payload bytes.
// ----------------------------------------------------------------------------
module sfp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  wire logic [7:0]    rx_byte_i,
  output logic               full,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output sfp_pkg::pld_t      q_item_o
);
  import sfp_pkg::*;

  typedef enum logic [1:0] {
    HuntIdle   = 2'd0,
    HuntHeader = 2'd1,
    HuntGather = 2'd2
  } hunt_e;

  hunt_e           state_q;
  logic [IdxW-1:0] cnt_q;
  logic [7:0]      header_q;
  logic [7:0]      command_q;
  logic            accept;

  assign full        = q_full_i;
  assign accept      = push && !q_full_i;
  assign cfg_ready_o = 1'b1;

  // Only bytes gathered after a full sync go into the queue.
  assign q_push_o      = accept && (state_q == HuntGather);
  assign q_item_o.idx  = cnt_q;
  assign q_item_o.data = rx_byte_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= '0;
      command_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegHeader) begin
        header_q <= cfg_data_i;
      end
      if (cfg_index_i == RegCommand) begin
        command_q <= cfg_data_i;
      end
    end
  end

  // Hunt state machine and payload byte counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HuntIdle;
      cnt_q   <= '0;
    end else if (accept) begin
      unique case (state_q)
        HuntIdle: begin
          if (rx_byte_i == header_q) begin
            state_q <= HuntHeader;
          end
        end
        HuntHeader: begin
          state_q <= (rx_byte_i == command_q) ? HuntGather : HuntIdle;
          cnt_q   <= '0;
        end
        HuntGather: begin
          if (cnt_q == LastIdx) begin
            state_q <= HuntIdle;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= HuntIdle;
          cnt_q   <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/sfp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Speed frame parser back end
// Runs the CRC over payload bytes, checks it and holds the result.
// ----------------------------------------------------------------------------
module sfp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire sfp_pkg::pld_t q_item_i,
  output logic               q_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output logic               frame_ok_o,
  output logic [31:0]        linear_bits_o,
  output logic [31:0]        angular_bits_o
);
  import sfp_pkg::*;

  localparam int unsigned StoreLen = CrcSpan + 1;

  logic [7:0]  store_q [StoreLen];
  logic [15:0] crc_q, crc_d;
  logic [31:0] lin_q, ang_q;
  logic        out_valid_q, ok_q;
  logic        is_last, take, take_last, ok;
  logic [15:0] rx_crc;

  // A final byte waits until the result register is free.
  assign is_last   = (q_item_i.idx == LastIdx);
  assign take      = !q_empty_i && (!is_last || !out_valid_q || pop);
  assign take_last = take && is_last;
  assign q_pop_o   = take;

  // Received CRC is the stored high byte and the current low byte.
  assign rx_crc = {store_q[CrcHiIdx], q_item_i.data};
  assign ok     = (rx_crc == crc_q);

  // CRC update restarts on the first payload byte.
  always_comb begin
    crc_d = crc_q;
    if (q_item_i.idx == '0) begin
      crc_d = crc_feed(CrcInit, q_item_i.data);
    end else if (q_item_i.idx < IdxW'(CrcSpan)) begin
      crc_d = crc_feed(crc_q, q_item_i.data);
    end
  end

  // Payload bytes up to the CRC high byte; no reset needed.
  always_ff @(posedge clk_i) begin
    if (take && (q_item_i.idx < IdxW'(StoreLen))) begin
      store_q[q_item_i.idx[$clog2(StoreLen)-1:0]] <= q_item_i.data;
    end
  end

  // CRC, held speeds and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      lin_q       <= '0;
      ang_q       <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (take) begin
        crc_q <= crc_d;
      end
      if (take_last) begin
        out_valid_q <= 1'b1;
        ok_q        <= ok;
        if (ok) begin
          lin_q <= {store_q[0], store_q[1], store_q[2], store_q[3]};
          ang_q <= {store_q[4], store_q[5], store_q[6], store_q[7]};
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty          = !out_valid_q;
  assign frame_ok_o     = ok_q;
  assign linear_bits_o  = lin_q;
  assign angular_bits_o = ang_q;

  // A completed frame always leaves a result waiting.
  a_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_last |=> out_valid_q)
    else $error("frame completed without a result");

  // A rejected frame leaves the held speeds alone.
  a_hold_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_last && !ok) |=> ($stable(lin_q) && $stable(ang_q)))
    else $error("held speed changed on a rejected frame");

  // The linear speed and pass flag never change while a result waits to be taken.
  a_hold_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> ($stable(lin_q) && $stable(ok_q)))
    else $error("waiting result changed");

endmodule
`default_nettype wire

FILE: sv/speed_frame_parser_crc16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Speed frame parser with CRC-16/MODBUS check
// Deframes header/command synced speed frames and checks their CRC.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle. A front end hunts for
// the header byte and then the command byte, and passes the ten payload
// bytes that follow through a two-entry queue to a back end, which runs
// CRC-16/MODBUS over bytes 0..7 one byte per cycle and compares it with
// bytes 8 (high) and 9 (low). The last byte of a frame is not taken while an
// earlier result is still waiting; the result is registered when it is taken:
// a pass flag and the last good linear and angular speeds as big-endian
// IEEE-754 bit patterns. Input stalls only when a result has not been taken
// and the queue behind it has filled. Header and command bytes (index 0 and
// 1, other indexes ignored) are written on the always-ready configuration
// port; the user must write them only while idle, not enforced by the block.
module speed_frame_parser_crc16 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             frame_ok_o,
  output logic [31:0]      linear_bits_o,
  output logic [31:0]      angular_bits_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  import sfp_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  pld_t q_wr_item, q_rd_item;

  // Front end: sync hunt and byte tagging.
  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .rx_byte_i   (rx_byte_i),
    .full        (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  // Queue between the two ends.
  sfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  // Back end: CRC, check and result register.
  sfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_rd_item),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .frame_ok_o     (frame_ok_o),
    .linear_bits_o  (linear_bits_o),
    .angular_bits_o (angular_bits_o)
  );

endmodule
`default_nettype wire
